>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CWTS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication starting in the next cycle.
`define CWTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error(msg);

`endif

>>> hdl/cwts_pkg.sv
// Types and constants of the cascaded window timing statistics block.
package cwts_pkg;

   localparam int SLOT_W          = 6;
   localparam int LEVEL_W         = 2;
   localparam int DUR_W           = 32;
   localparam int CALLS_W         = 32;
   localparam int TOTAL_W         = 48;
   localparam int MAX_W           = 32;
   localparam int PERIOD_W        = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int NUM_PERIOD_REGS = 4;

   typedef logic [1:0] action_type;

   localparam action_type ACT_RECORD = 2'd0;
   localparam action_type ACT_TICK   = 2'd1;
   localparam action_type ACT_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LEVEL0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LEVEL1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LEVEL2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LEVEL3 = 2'd3;

   localparam logic [PERIOD_W-1:0] PERIOD_LEVEL0_RESET = 16'd5;
   localparam logic [PERIOD_W-1:0] PERIOD_LEVEL1_RESET = 16'd60;
   localparam logic [PERIOD_W-1:0] PERIOD_LEVEL2_RESET = 16'd300;
   localparam logic [PERIOD_W-1:0] PERIOD_LEVEL3_RESET = 16'd3600;

   typedef struct packed {
      action_type         action;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] level;
      logic [DUR_W-1:0]   duration_us;
      logic               time_only;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  read_slot;
      logic [LEVEL_W-1:0] read_level;
      logic [CALLS_W-1:0] period_calls;
      logic [TOTAL_W-1:0] period_total_us;
      logic [MAX_W-1:0]   period_max_us;
   } rsp_type;

   typedef struct packed {
      logic [CALLS_W-1:0] calls;
      logic [TOTAL_W-1:0] total;
      logic [MAX_W-1:0]   max_us;
   } stat_type;

endpackage

>>> hdl/cwts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cwts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cascaded_window_timing_stats_top.sv
// Cascaded window timing statistics: per-slot accumulators rolled over in four window levels.
//
// A record passes through S_RECORD and a read through S_READ, plus any wait there for the
// result register to be taken. A tick that rolls at least one level sweeps every entry of
// the accumulator and previous-period memories, one entry per cycle; a tick that rolls no
// level stays in S_IDLE. After reset a clearing pass zeroes both memories, during which
// req_stall stays high; configuration writes are taken at any time. This sequencing follows
// from the single read and single write port of each memory and the one shared saturating
// merge unit.
module cascaded_window_timing_stats_top #(
   parameter int NUM_SLOTS  = 64,
   parameter int NUM_LEVELS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cwts_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cwts_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cwts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cwts_pkg::PERIOD_W-1:0]      csr_wdata
);

   import cwts_pkg::*;

   localparam int ENTRIES = NUM_SLOTS * NUM_LEVELS;
   localparam int ENTRY_W = $clog2(ENTRIES);
   localparam int LVL_W   = $clog2(NUM_LEVELS);
   localparam int STAT_W  = $bits(stat_type);
   localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(ENTRIES - 1);
   localparam logic [LVL_W-1:0]   LAST_LEVEL = LVL_W'(NUM_LEVELS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RECORD,
      S_TICK,
      S_READ
   } state_type;

   state_type                 state_ff, state_in;
   logic [ENTRY_W-1:0]        addr_ff, addr_in;
   logic [LVL_W-1:0]          lvl_ff, lvl_in;
   logic [NUM_LEVELS-1:0]     roll_ff, roll_in;
   stat_type                  carry_ff, carry_in;
   logic                      carry_vld_ff, carry_vld_in;
   logic [DUR_W-1:0]          dur_ff, dur_in;
   logic                      time_only_ff, time_only_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [LEVEL_W-1:0]        level_ff, level_in;
   logic                      hit_ff, hit_in;
   logic [PERIOD_W-1:0]       cnt_ff [NUM_LEVELS];
   logic [PERIOD_W-1:0]       cnt_in [NUM_LEVELS];
   logic [PERIOD_W-1:0]       period_ff [NUM_PERIOD_REGS];
   logic [PERIOD_W-1:0]       period_in [NUM_PERIOD_REGS];
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [NUM_LEVELS-1:0]     roll_now;
   logic [PERIOD_W:0]         cnt_inc [NUM_LEVELS];
   logic                      req_in_slot;
   logic                      req_in_level;
   logic [ENTRY_W-1:0]        req_base;
   logic [ENTRY_W-1:0]        req_idx;
   logic [ENTRY_W-1:0]        rd_addr;
   stat_type                  acc_rd, prev_rd;
   stat_type                  merge_b, merged;
   logic                      acc_we, prev_we;
   stat_type                  acc_wdata, prev_wdata;
   logic                      roll_cur;

   function automatic stat_type stat_merge(stat_type a, stat_type b);
      logic [CALLS_W:0] c;
      logic [TOTAL_W:0] t;
      stat_type         r;
      c = {1'b0, a.calls} + {1'b0, b.calls};
      t = {1'b0, a.total} + {1'b0, b.total};
      r.calls  = c[CALLS_W] ? '1 : c[CALLS_W-1:0];
      r.total  = t[TOTAL_W] ? '1 : t[TOTAL_W-1:0];
      r.max_us = (b.max_us > a.max_us) ? b.max_us : a.max_us;
      return r;
   endfunction

   cwts_ram #(.WIDTH(STAT_W), .DEPTH(ENTRIES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (addr_ff),
      .wr_data (acc_wdata),
      .rd_addr (rd_addr),
      .rd_data (acc_rd)
   );

   cwts_ram #(.WIDTH(STAT_W), .DEPTH(ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (addr_ff),
      .wr_data (prev_wdata),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   assign req_in_slot  = 32'(req_data.slot) < NUM_SLOTS;
   assign req_in_level = 32'(req_data.level) < NUM_LEVELS;
   assign req_base     = ENTRY_W'(req_data.slot) * ENTRY_W'(NUM_LEVELS);
   assign req_idx      = req_base + ENTRY_W'(req_data.level);
   assign roll_cur     = roll_ff[lvl_ff];

   always_comb begin
      logic [1:0] pidx;
      pidx = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         pidx        = (l < NUM_PERIOD_REGS) ? 2'(l) : 2'(NUM_PERIOD_REGS - 1);
         cnt_inc[l]  = {1'b0, cnt_ff[l]} + (PERIOD_W+1)'(1);
         roll_now[l] = cnt_inc[l] >= {1'b0, period_ff[pidx]};
      end
   end

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            if (req_data.action == ACT_READ) begin
               rd_addr = req_idx;
            end else if (req_data.action == ACT_TICK) begin
               rd_addr = '0;
            end else begin
               rd_addr = req_base;
            end
         end
         S_TICK:  rd_addr = addr_ff + ENTRY_W'(1);
         default: rd_addr = addr_ff;
      endcase
   end

   always_comb begin
      if (state_ff == S_RECORD) begin
         merge_b.calls  = {{(CALLS_W-1){1'b0}}, ~time_only_ff};
         merge_b.total  = TOTAL_W'(dur_ff);
         merge_b.max_us = time_only_ff ? '0 : dur_ff;
      end else if (carry_vld_ff) begin
         merge_b = carry_ff;
      end else begin
         merge_b = '0;
      end
   end

   assign merged = stat_merge(acc_rd, merge_b);

   assign acc_we     = (state_ff == S_CLEAR) || (state_ff == S_RECORD) || (state_ff == S_TICK);
   assign acc_wdata  = ((state_ff == S_CLEAR) || ((state_ff == S_TICK) && roll_cur)) ? '0
                                                                                      : merged;
   assign prev_we    = (state_ff == S_CLEAR) || ((state_ff == S_TICK) && roll_cur);
   assign prev_wdata = (state_ff == S_CLEAR) ? '0 : merged;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      lvl_in       = lvl_ff;
      roll_in      = roll_ff;
      carry_in     = carry_ff;
      carry_vld_in = carry_vld_ff;
      dur_in       = dur_ff;
      time_only_in = time_only_ff;
      slot_in      = slot_ff;
      level_in     = level_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      period_in    = period_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         period_in[csr_index] = csr_wdata;
      end

      case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + ENTRY_W'(1);
            if (addr_ff == LAST_ENTRY) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.action)
                  ACT_RECORD: begin
                     if (req_in_slot) begin
                        addr_in      = req_base;
                        dur_in       = req_data.duration_us;
                        time_only_in = req_data.time_only;
                        state_in     = S_RECORD;
                     end
                  end
                  ACT_TICK: begin
                     for (int l = 0; l < NUM_LEVELS; l++) begin
                        cnt_in[l] = roll_now[l] ? '0 : cnt_inc[l][PERIOD_W-1:0];
                     end
                     roll_in = roll_now;
                     if (|roll_now) begin
                        addr_in      = '0;
                        lvl_in       = '0;
                        carry_vld_in = 1'b0;
                        state_in     = S_TICK;
                     end
                  end
                  ACT_READ: begin
                     addr_in  = req_idx;
                     slot_in  = req_data.slot;
                     level_in = req_data.level;
                     hit_in   = req_in_slot && req_in_level;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_RECORD: begin
            state_in = S_IDLE;
         end
         S_TICK: begin
            if (roll_cur) begin
               carry_in     = prev_rd;
               carry_vld_in = lvl_ff != LAST_LEVEL;
            end else begin
               carry_vld_in = 1'b0;
            end
            lvl_in  = (lvl_ff == LAST_LEVEL) ? '0 : lvl_ff + LVL_W'(1);
            addr_in = addr_ff + ENTRY_W'(1);
            if (addr_ff == LAST_ENTRY) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.read_slot       = slot_ff;
               rsp_in.read_level      = level_ff;
               rsp_in.period_calls    = hit_ff ? prev_rd.calls : '0;
               rsp_in.period_total_us = hit_ff ? prev_rd.total : '0;
               rsp_in.period_max_us   = hit_ff ? prev_rd.max_us : '0;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         lvl_ff       <= '0;
         roll_ff      <= '0;
         carry_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            cnt_ff[l] <= '0;
         end
         period_ff[CSR_PERIOD_LEVEL0] <= PERIOD_LEVEL0_RESET;
         period_ff[CSR_PERIOD_LEVEL1] <= PERIOD_LEVEL1_RESET;
         period_ff[CSR_PERIOD_LEVEL2] <= PERIOD_LEVEL2_RESET;
         period_ff[CSR_PERIOD_LEVEL3] <= PERIOD_LEVEL3_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         lvl_ff       <= lvl_in;
         roll_ff      <= roll_in;
         carry_vld_ff <= carry_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         period_ff    <= period_in;
      end
      carry_ff     <= carry_in;
      dur_ff       <= dur_in;
      time_only_ff <= time_only_in;
      slot_ff      <= slot_in;
      level_ff     <= level_in;
      hit_ff       <= hit_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

>>> hdl/cwts_checker.sv
// Port-level assertion checker for the cascaded window timing statistics block, with its bind.
`include "assert_macros.svh"

module cwts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input cwts_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cwts_pkg::rsp_type rsp_data
);

   import cwts_pkg::*;

   `CWTS_ASSERT_IMPLIES(a_clear_after_reset, clock, reset, $past(reset), req_stall, "input taken during clearing pass")

   `CWTS_ASSERT_NEXT(a_read_result, clock, reset, req_valid && !req_stall && req_data.action == ACT_READ && !rsp_valid, ##1 (rsp_valid && rsp_data.read_slot == $past(req_data.slot, 2) && rsp_data.read_level == $past(req_data.level, 2)), "read result missing or wrong echo")

   `CWTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, (rsp_valid && $stable(rsp_data)), "stalled result word changed")

   `CWTS_ASSERT_IMPLIES(a_max_within_total, clock, reset, rsp_valid, TOTAL_W'(rsp_data.period_max_us) <= rsp_data.period_total_us, "maximum exceeds total")

   `CWTS_ASSERT_IMPLIES(a_max_needs_calls, clock, reset, rsp_valid && rsp_data.period_calls == '0, rsp_data.period_max_us == '0, "maximum without calls")

endmodule

bind cascaded_window_timing_stats_top cwts_checker u_cwts_checker (.*);
